### rtl/ssd_pkg.sv
// Shared constants and types of the spectral sharpen and dehalo datapath.
`default_nettype none

package ssd_pkg;

  localparam int unsigned COEF_BITS_DEF = 24;

  // Power word and configuration port widths.
  localparam int unsigned PW        = 48;
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [PW-1:0] PMAX    = {PW{1'b1}};

  // Sharpen divider: numerator and denominator up to 98 bits, 32 fraction bits.
  localparam int unsigned SH_W = 98;
  localparam int unsigned SH_Q = 32;
  // Dehalo divider: up to 81 bits, 24 fraction bits.
  localparam int unsigned DH_W = 81;
  localparam int unsigned DH_Q = 24;

  // Square root of the 33-bit sharpen ratio gives a 17-bit root.
  localparam int unsigned SQ_VW    = SH_Q + 1;
  localparam int unsigned SQ_STEPS = (SQ_VW + 1) / 2;

  // Gain times weight, signed.
  localparam int unsigned GW = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHARPEN_GAIN  = 3'd0,
    CFG_DEHALO_GAIN   = 3'd1,
    CFG_SIGMA_MIN     = 3'd2,
    CFG_SIGMA_MAX     = 3'd3,
    CFG_HALO_THRESH   = 3'd4,
    CFG_GRID_FRACTION = 3'd5,
    CFG_DEGRID_ENABLE = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

### rtl/ssd_div_pipe.sv
// Pipelined restoring divider giving floor(num * 2^QBITS / den), one quotient bit per stage.
`default_nettype none

module ssd_div_pipe #(
  parameter int unsigned W     = ssd_pkg::SH_W,
  parameter int unsigned QBITS = ssd_pkg::SH_Q
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [W-1:0]   num_i,
  input  wire logic [W-1:0]   den_i,
  output logic      [QBITS:0] quo_o
);

  logic [W-1:0]   rem_q [0:QBITS];
  logic [W-1:0]   den_q [0:QBITS];
  logic [QBITS:0] quo_q [0:QBITS];

  logic [W-1:0]   rem_d [0:QBITS];
  logic [QBITS:0] quo_d [0:QBITS];

  // The first stage decides the integer bit; num never exceeds den.
  always_comb begin
    if (num_i >= den_i) begin
      rem_d[0] = num_i - den_i;
      quo_d[0] = (QBITS+1)'(1);
    end else begin
      rem_d[0] = num_i;
      quo_d[0] = '0;
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_step
    logic [W:0] sh;
    logic       ge;
    assign sh = {rem_q[j-1], 1'b0};
    assign ge = (sh >= {1'b0, den_q[j-1]});
    assign rem_d[j] = ge ? W'(sh - {1'b0, den_q[j-1]}) : sh[W-1:0];
    assign quo_d[j] = {quo_q[j-1][QBITS-1:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      den_q[0] <= den_i;
      quo_q[0] <= quo_d[0];
      for (int k = 1; k <= QBITS; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[QBITS];

endmodule

`default_nettype wire

### rtl/ssd_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module ssd_sqrt_pipe #(
  parameter int unsigned VW    = ssd_pkg::SQ_VW,
  localparam int unsigned STEPS = (VW + 1) / 2,
  localparam int unsigned RW    = 2 * STEPS + 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [VW-1:0]    val_i,
  output logic      [STEPS-1:0] root_o
);

  logic [VW-1:0] v_q [0:STEPS-1];
  logic [RW-1:0] r_q [0:STEPS-1];
  logic [VW-1:0] v_d [0:STEPS-1];
  logic [RW-1:0] r_d [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - i));
    logic [VW-1:0] v_in;
    logic [RW-1:0] r_in;
    logic [RW-1:0] t;
    if (i == 0) begin : g_first
      assign v_in = val_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign r_in = r_q[i-1];
    end
    assign t = r_in + BIT;
    always_comb begin
      if (RW'(v_in) >= t) begin
        v_d[i] = VW'(RW'(v_in) - t);
        r_d[i] = (r_in >> 1) + BIT;
      end else begin
        v_d[i] = v_in;
        r_d[i] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STEPS; k++) begin
        v_q[k] <= v_d[k];
        r_q[k] <= r_d[k];
      end
    end
  end

  assign root_o = r_q[STEPS-1][STEPS-1:0];

endmodule

`default_nettype wire

### rtl/spectral_sharpen_dehalo_core.sv
// Top level of the spectral sharpen and dehalo bin processor.
//
// One complex spectral bin enters per word on the s_axis channel, with its
// grid sample and its sharpen and dehalo weights; one scaled bin leaves per
// word on the m_axis channel, in the same order. Configuration registers are
// written through cfg_we_i / cfg_idx_i / cfg_data_i and must only change
// while no word is in flight; an index beyond the register list is ignored.
//
// The datapath is a single pipeline of 63 register stages, and one word is
// taken every cycle while the receiver does not stall. The length is set
// by the sharpen divider (33 stages, one quotient bit each) and the square
// root behind it (17 stages, one root bit each).
//
// Reset clears all configuration registers and every stage valid bit. When
// the receiver stalls, the whole pipeline holds: s_axis_tready follows the
// output register being empty or taken, so no word is lost or repeated.
`default_nettype none

module spectral_sharpen_dehalo_core #(
  parameter  int unsigned COEF_BITS = ssd_pkg::COEF_BITS_DEF,
  localparam int unsigned IN_W  = ((4 * COEF_BITS + 32 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COEF_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ssd_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // coef_re, coef_im, grid_re, grid_im, sharpen_weight, dehalo_weight
  input  wire logic [IN_W-1:0]                s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // result_re, result_im
  output logic [OUT_W-1:0]                    m_axis_tdata
);

  localparam int unsigned CB   = COEF_BITS;
  localparam int unsigned PW   = ssd_pkg::PW;
  localparam int unsigned GPW  = CB + 17;          // grid times fraction
  localparam int unsigned GCW  = CB + 1;           // grid correction
  localparam int unsigned CRW  = CB + 2;           // corrected bin
  localparam int unsigned MW   = (CRW > 25) ? CRW : 25;
  localparam int unsigned GW   = ssd_pkg::GW;
  localparam int unsigned SQS  = ssd_pkg::SQ_STEPS;
  localparam int unsigned PDW  = GW + SQS + 1;      // gain * weight * root
  localparam int unsigned SFW  = PDW - 16 + 2;     // sharpen factor
  localparam int unsigned DQW  = ssd_pkg::DH_Q + 1;
  localparam int unsigned FPW  = SFW + DQW + 1;    // factor product
  localparam int unsigned FW   = FPW - 24 + 1;     // combined factor
  localparam int unsigned PRW  = CRW + FW;         // bin times factor
  localparam int unsigned RW   = PRW - 24 + 2;     // scaled plus correction
  localparam int unsigned SHW  = ssd_pkg::SH_W;
  localparam int unsigned DHW  = ssd_pkg::DH_W;

  // Stage indexes in the side pipeline; index 0 holds the corrected bin.
  localparam int unsigned IDX_DIN  = 5;
  localparam int unsigned IDX_SDIV = IDX_DIN + ssd_pkg::SH_Q + 1;
  localparam int unsigned IDX_DDIV = IDX_DIN + ssd_pkg::DH_Q + 1;
  localparam int unsigned IDX_SQ   = IDX_SDIV + SQS;
  localparam int unsigned NSD      = IDX_SQ + 6;
  localparam int unsigned DQD      = IDX_SQ + 2 - IDX_DDIV;

  localparam logic signed [RW-1:0] SAT_HI = {{(RW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic                  bypass;
    logic [CB-1:0]         coef_re;
    logic [CB-1:0]         coef_im;
    logic signed [GCW-1:0] gr;
    logic signed [GCW-1:0] gi;
    logic signed [CRW-1:0] cr;
    logic signed [CRW-1:0] ci;
    logic signed [GW-1:0]  gw;
  } side_t;

  // Configuration registers.
  logic signed [15:0] sg_q;
  logic [15:0]        dg_q;
  logic [PW-1:0]      smin_q, smax_q, ht_q;
  logic [15:0]        gf_q;
  logic               de_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_q   <= '0;
      dg_q   <= '0;
      smin_q <= '0;
      smax_q <= '0;
      ht_q   <= '0;
      gf_q   <= '0;
      de_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ssd_pkg::cfg_idx_e'(cfg_idx_i))
        ssd_pkg::CFG_SHARPEN_GAIN:  sg_q   <= cfg_data_i[15:0];
        ssd_pkg::CFG_DEHALO_GAIN:   dg_q   <= cfg_data_i[15:0];
        ssd_pkg::CFG_SIGMA_MIN:     smin_q <= cfg_data_i[PW-1:0];
        ssd_pkg::CFG_SIGMA_MAX:     smax_q <= cfg_data_i[PW-1:0];
        ssd_pkg::CFG_HALO_THRESH:   ht_q   <= cfg_data_i[PW-1:0];
        ssd_pkg::CFG_GRID_FRACTION: gf_q   <= cfg_data_i[15:0];
        ssd_pkg::CFG_DEGRID_ENABLE: de_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or taken.
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input word fields.
  logic signed [CB-1:0] in_cre, in_cim, in_gre, in_gim;
  logic [15:0]          in_sw, in_dw;
  assign in_cre = s_axis_tdata[CB-1:0];
  assign in_cim = s_axis_tdata[2*CB-1:CB];
  assign in_gre = s_axis_tdata[3*CB-1:2*CB];
  assign in_gim = s_axis_tdata[4*CB-1:3*CB];
  assign in_sw  = s_axis_tdata[4*CB+15:4*CB];
  assign in_dw  = s_axis_tdata[4*CB+31:4*CB+16];

  // Valid bits.
  logic v1_q;
  logic vl_q [0:NSD-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < NSD; k++) vl_q[k] <= 1'b0;
    end else if (en) begin
      v1_q      <= s_axis_tvalid;
      vl_q[0]   <= v1_q;
      for (int k = 1; k < NSD; k++) vl_q[k] <= vl_q[k-1];
      out_vld_q <= vl_q[NSD-1];
    end
  end

  // Stage 1: grid products and weight products.
  logic signed [GPW-1:0] gp_re_d, gp_im_d, gp_re_q, gp_im_q;
  logic signed [GW-1:0]  gw_d, gw1_q;
  logic [31:0]           dgw_d;
  logic signed [CB-1:0]  cre1_q, cim1_q;
  logic                  byp1_q;
  logic [31:0]           dgw_q [0:4];

  always_comb begin
    gp_re_d = $signed(in_gre) * $signed({1'b0, gf_q});
    gp_im_d = $signed(in_gim) * $signed({1'b0, gf_q});
    if (!de_q) begin
      gp_re_d = '0;
      gp_im_d = '0;
    end
    gw_d  = $signed(sg_q) * $signed({1'b0, in_sw});
    dgw_d = dg_q * in_dw;
  end

  // Stage 2: round the grid correction and remove it from the bin.
  side_t                 sd_q [0:NSD-1];
  side_t                 sd_d;
  logic [GPW-1:0]        gm_re, gm_im;
  logic [GCW-1:0]        gr_m, gi_m;

  always_comb begin
    gm_re = gp_re_q[GPW-1] ? GPW'(-gp_re_q) : GPW'(gp_re_q);
    gm_im = gp_im_q[GPW-1] ? GPW'(-gp_im_q) : GPW'(gp_im_q);
    gr_m  = GCW'((gm_re + GPW'(32768)) >> 16);
    gi_m  = GCW'((gm_im + GPW'(32768)) >> 16);
    sd_d.bypass  = byp1_q;
    sd_d.coef_re = cre1_q;
    sd_d.coef_im = cim1_q;
    sd_d.gr      = gp_re_q[GPW-1] ? -$signed(gr_m) : $signed(gr_m);
    sd_d.gi      = gp_im_q[GPW-1] ? -$signed(gi_m) : $signed(gi_m);
    sd_d.cr      = CRW'(cre1_q) - CRW'(sd_d.gr);
    sd_d.ci      = CRW'(cim1_q) - CRW'(sd_d.gi);
    sd_d.gw      = gw1_q;
  end

  // Stage 3: squares, with overflow when a magnitude reaches 2^24.
  logic [MW-1:0]  mr, mi;
  logic [PW-1:0]  sqr_q, sqi_q;
  logic           ovf_q;
  assign mr = MW'(sd_q[0].cr[CRW-1] ? CRW'(-sd_q[0].cr) : CRW'(sd_q[0].cr));
  assign mi = MW'(sd_q[0].ci[CRW-1] ? CRW'(-sd_q[0].ci) : CRW'(sd_q[0].ci));

  // Stage 4: power with the one-LSB epsilon, clamped to 48 bits.
  logic [PW+1:0] psum;
  logic [PW-1:0] p4_q;
  assign psum = {2'b0, sqr_q} + {2'b0, sqi_q} + (PW+2)'(1);

  // Stage 5: power sums. Stage 6: partial products. Stage 7: full products.
  logic [PW-1:0] p5_q;
  logic [PW:0]   pmin5_q, pmax5_q, pht5_q, pht6_q;
  logic [47:0]   n_ll_q, n_lh_q, n_hl_q, n_hh_q, d_ll_q;
  logic [48:0]   d_lh_q, d_hl_q;
  logic [49:0]   d_hh_q;
  logic [55:0]   e_l_q, e_h_q;
  logic [SHW-1:0] num7_q, den7_q;
  logic [DHW-1:0] a7_q, b7_q;
  logic [DHW-1:0] a7_d;
  assign a7_d = DHW'({pht6_q, 24'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      gp_re_q <= gp_re_d;
      gp_im_q <= gp_im_d;
      gw1_q   <= gw_d;
      cre1_q  <= in_cre;
      cim1_q  <= in_cim;
      byp1_q  <= (sg_q == '0) && (dg_q == '0);
      dgw_q[0] <= dgw_d;
      for (int k = 1; k < 5; k++) dgw_q[k] <= dgw_q[k-1];

      sd_q[0] <= sd_d;
      for (int k = 1; k < NSD; k++) sd_q[k] <= sd_q[k-1];

      sqr_q <= mr[23:0] * mr[23:0];
      sqi_q <= mi[23:0] * mi[23:0];
      ovf_q <= (|mr[MW-1:24]) || (|mi[MW-1:24]);

      p4_q <= (ovf_q || (|psum[PW+1:PW])) ? ssd_pkg::PMAX : psum[PW-1:0];

      p5_q    <= p4_q;
      pmin5_q <= {1'b0, p4_q} + {1'b0, smin_q};
      pmax5_q <= {1'b0, p4_q} + {1'b0, smax_q};
      pht5_q  <= {1'b0, p4_q} + {1'b0, ht_q};

      n_ll_q <= p5_q[23:0]  * smax_q[23:0];
      n_lh_q <= p5_q[23:0]  * smax_q[47:24];
      n_hl_q <= p5_q[47:24] * smax_q[23:0];
      n_hh_q <= p5_q[47:24] * smax_q[47:24];
      d_ll_q <= pmin5_q[23:0]  * pmax5_q[23:0];
      d_lh_q <= pmin5_q[23:0]  * pmax5_q[48:24];
      d_hl_q <= pmin5_q[48:24] * pmax5_q[23:0];
      d_hh_q <= pmin5_q[48:24] * pmax5_q[48:24];
      e_l_q  <= dgw_q[4] * p5_q[23:0];
      e_h_q  <= dgw_q[4] * p5_q[47:24];
      pht6_q <= pht5_q;

      num7_q <= SHW'(n_ll_q) + (SHW'(n_lh_q) << 24) + (SHW'(n_hl_q) << 24)
                + (SHW'(n_hh_q) << 48);
      den7_q <= SHW'(d_ll_q) + (SHW'(d_lh_q) << 24) + (SHW'(d_hl_q) << 24)
                + (SHW'(d_hh_q) << 48);
      a7_q   <= a7_d;
      b7_q   <= a7_d + DHW'(e_l_q) + (DHW'(e_h_q) << 24);
    end
  end

  // Dividers run side by side; the dehalo quotient then waits in a delay line.
  logic [ssd_pkg::SH_Q:0] sdiv_q;
  logic [DQW-1:0]         ddiv_q;
  logic [SQS-1:0]         root;

  ssd_div_pipe #(.W(SHW), .QBITS(ssd_pkg::SH_Q)) u_ssd_div_sharp (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num7_q),
    .den_i (den7_q),
    .quo_o (sdiv_q)
  );

  ssd_div_pipe #(.W(DHW), .QBITS(ssd_pkg::DH_Q)) u_ssd_div_halo (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (a7_q),
    .den_i (b7_q),
    .quo_o (ddiv_q)
  );

  ssd_sqrt_pipe #(.VW(ssd_pkg::SQ_VW)) u_ssd_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (sdiv_q),
    .root_o (root)
  );

  logic [DQW-1:0] dq_q [0:DQD-1];

  // Tail stages: sharpen factor, combined factor and scaling.
  logic signed [PDW-1:0] pd_q;
  logic [PDW-1:0]        pd_m;
  logic [SFW-1:0]        sf_m;
  logic signed [SFW-1:0] sf_q;
  logic signed [FPW-1:0] fp_q;
  logic [FPW-1:0]        fp_m;
  logic [FW-1:0]         f_m;
  logic signed [FW-1:0]  f_q;
  logic [CRW-1:0]        mc_re, mc_im;
  logic [FW-1:0]         mf;
  logic [PRW-1:0]        pr_re_q, pr_im_q;
  logic                  ng_re_q, ng_im_q;

  assign pd_m  = pd_q[PDW-1] ? PDW'(-pd_q) : PDW'(pd_q);
  assign sf_m  = SFW'((pd_m + PDW'(32768)) >> 16);
  assign fp_m  = fp_q[FPW-1] ? FPW'(-fp_q) : FPW'(fp_q);
  assign f_m   = FW'((fp_m + FPW'(1 << 23)) >> 24);
  assign mc_re = sd_q[NSD-2].cr[CRW-1] ? CRW'(-sd_q[NSD-2].cr) : CRW'(sd_q[NSD-2].cr);
  assign mc_im = sd_q[NSD-2].ci[CRW-1] ? CRW'(-sd_q[NSD-2].ci) : CRW'(sd_q[NSD-2].ci);
  assign mf    = f_q[FW-1] ? FW'(-f_q) : FW'(f_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq_q[0] <= ddiv_q;
      for (int k = 1; k < DQD; k++) dq_q[k] <= dq_q[k-1];

      pd_q <= $signed(sd_q[IDX_SQ].gw) * $signed({1'b0, root});
      sf_q <= SFW'(1 << 24) + (pd_q[PDW-1] ? -$signed(sf_m) : $signed(sf_m));
      fp_q <= sf_q * $signed({1'b0, dq_q[DQD-1]});
      f_q  <= fp_q[FPW-1] ? -$signed(f_m) : $signed(f_m);
      pr_re_q <= PRW'(mc_re) * PRW'(mf);
      pr_im_q <= PRW'(mc_im) * PRW'(mf);
      ng_re_q <= sd_q[NSD-2].cr[CRW-1] != f_q[FW-1];
      ng_im_q <= sd_q[NSD-2].ci[CRW-1] != f_q[FW-1];
    end
  end

  // Output register: round, restore the grid correction and saturate, or pass the bin through.
  logic [RW-1:0]        q_re, q_im;
  logic signed [RW-1:0] r_re, r_im;
  logic [CB-1:0]        res_re_d, res_im_d, res_re_q, res_im_q;

  always_comb begin
    q_re = RW'((pr_re_q + PRW'(1 << 23)) >> 24);
    q_im = RW'((pr_im_q + PRW'(1 << 23)) >> 24);
    r_re = (ng_re_q ? -$signed(q_re) : $signed(q_re)) + RW'(sd_q[NSD-1].gr);
    r_im = (ng_im_q ? -$signed(q_im) : $signed(q_im)) + RW'(sd_q[NSD-1].gi);
    priority if (r_re > SAT_HI) res_re_d = SAT_HI[CB-1:0];
    else if (r_re < SAT_LO)     res_re_d = SAT_LO[CB-1:0];
    else                        res_re_d = r_re[CB-1:0];
    priority if (r_im > SAT_HI) res_im_d = SAT_HI[CB-1:0];
    else if (r_im < SAT_LO)     res_im_d = SAT_LO[CB-1:0];
    else                        res_im_d = r_im[CB-1:0];
    // With both gains off the bin passes through untouched.
    if (sd_q[NSD-1].bypass) begin
      res_re_d = sd_q[NSD-1].coef_re;
      res_im_d = sd_q[NSD-1].coef_im;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({res_im_q, res_re_q});

endmodule

`default_nettype wire

### rtl/ssd_chk.sv
// Port-level checker for the spectral sharpen and dehalo core, with its bind.
`default_nettype none

module ssd_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // The input side is ready exactly when the output register can move.
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // A new result only appears when the pipeline has just moved.
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("result appeared while the pipeline was held");

endmodule

bind spectral_sharpen_dehalo_core ssd_chk u_ssd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

### sim/ssd_bin_checker.sv
// Watches the stream and configuration channels, predicts each scaled bin and compares.
`timescale 1ns / 100ps

module ssd_bin_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ssd_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic [127:0]                  s_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [47:0]                   m_axis_tdata,
  output int                                 errors_o,
  output int                                 pending_o,
  output int                                 checked_o
);

  // Shadow copy of the configuration registers.
  logic [15:0]            sh_gain, dh_gain, grid_frac;
  logic [ssd_pkg::PW-1:0] sig_min, sig_max, halo_thr;
  logic                   degrid_on;

  logic [47:0] expected_bins[$];

  function automatic logic [63:0] mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint rnd_away(longint x, int n);
    logic [63:0] m;
    m = (mag(x) + (64'd1 << (n - 1))) >> n;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] bin_power(longint cr, longint ci);
    logic [63:0] mr, mi, s;
    mr = mag(cr);
    mi = mag(ci);
    if (mr >= (64'd1 << 24) || mi >= (64'd1 << 24)) return {16'd0, ssd_pkg::PMAX};
    s = mr * mr + mi * mi + 64'd1;
    return (s > {16'd0, ssd_pkg::PMAX}) ? {16'd0, ssd_pkg::PMAX} : s;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int i = 16; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [23:0] scale_sat(longint c, longint f, longint gc);
    logic [127:0] prod;
    longint q, r;
    prod = {64'd0, mag(c)} * {64'd0, mag(f)};
    q = longint'((prod + (128'd1 << 23)) >> 24);
    if ((c < 0) != (f < 0)) q = -q;
    r = q + gc;
    if (r < -(longint'(1) << 23)) r = -(longint'(1) << 23);
    if (r > (longint'(1) << 23) - 1) r = (longint'(1) << 23) - 1;
    return r[23:0];
  endfunction

  function automatic logic [47:0] predict_bin(logic [127:0] d);
    longint gain, gre, gim, cr, ci, sf, df, f;
    logic [63:0]  p, s;
    logic [129:0] num, den, ratio;
    logic [111:0] a, b;
    gain = longint'($signed(sh_gain));
    gre  = 0;
    gim  = 0;
    sf   = longint'(1) << 24;
    df   = longint'(1) << 24;
    // Both gains off: the bin passes untouched, degrid included.
    if (gain == 0 && dh_gain == 0) return d[47:0];
    if (degrid_on) begin
      gre = rnd_away(longint'($signed(d[71:48])) * longint'(grid_frac), 16);
      gim = rnd_away(longint'($signed(d[95:72])) * longint'(grid_frac), 16);
    end
    cr = longint'($signed(d[23:0])) - gre;
    ci = longint'($signed(d[47:24])) - gim;
    p  = bin_power(cr, ci);
    if (gain != 0) begin
      num   = {66'd0, p} * {82'd0, sig_max};
      den   = ({66'd0, p} + sig_min) * ({66'd0, p} + sig_max);
      ratio = (num << 32) / den;
      s     = root_floor(ratio[63:0]);
      sf    = sf + rnd_away(gain * longint'(d[111:96]) * longint'(s), 16);
    end
    if (dh_gain != 0) begin
      a  = ({48'd0, p} + halo_thr) << 24;
      b  = a + ({96'd0, dh_gain} * {96'd0, d[127:112]}) * {48'd0, p};
      a  = (a << 24) / b;
      df = longint'(a[63:0]);
    end
    if (gain != 0 && dh_gain != 0) f = rnd_away(sf * df, 24);
    else if (gain != 0) f = sf;
    else f = df;
    return {scale_sat(ci, f, gim), scale_sat(cr, f, gre)};
  endfunction

  assign pending_o = expected_bins.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [47:0] want;
    if (!rst_ni) begin
      sh_gain   <= '0;
      dh_gain   <= '0;
      sig_min   <= '0;
      sig_max   <= '0;
      halo_thr  <= '0;
      grid_frac <= '0;
      degrid_on <= 1'b0;
      errors_o  <= 0;
      checked_o <= 0;
      expected_bins.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ssd_pkg::CFG_SHARPEN_GAIN:  sh_gain   <= cfg_data_i[15:0];
          ssd_pkg::CFG_DEHALO_GAIN:   dh_gain   <= cfg_data_i[15:0];
          ssd_pkg::CFG_SIGMA_MIN:     sig_min   <= cfg_data_i;
          ssd_pkg::CFG_SIGMA_MAX:     sig_max   <= cfg_data_i;
          ssd_pkg::CFG_HALO_THRESH:   halo_thr  <= cfg_data_i;
          ssd_pkg::CFG_GRID_FRACTION: grid_frac <= cfg_data_i[15:0];
          ssd_pkg::CFG_DEGRID_ENABLE: degrid_on <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_bins.push_back(predict_bin(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o <= checked_o + 1;
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, m_axis_tdata);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_bins.pop_front();
          if (want[23:0] !== m_axis_tdata[23:0]) begin
            $display("%0t: result_re expected %h actual %h", $time, want[23:0],
                     m_axis_tdata[23:0]);
          end
          if (want[47:24] !== m_axis_tdata[47:24]) begin
            $display("%0t: result_im expected %h actual %h", $time, want[47:24],
                     m_axis_tdata[47:24]);
          end
          if (want !== m_axis_tdata) errors_o <= errors_o + 1;
        end
      end
    end
  end

endmodule

### sim/tb_spectral_sharpen_dehalo_core.sv
// Stimulus, configuration phases and verdict for the spectral sharpen and dehalo core.
`timescale 1ns / 100ps

module tb_spectral_sharpen_dehalo_core;

  // Index past the register list; writes to it must be dropped by the block.
  localparam logic [ssd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  // Pipeline depth is 63 stages; give a margin before touching registers.
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 10;

  logic clk, rst_n;
  logic cfg_we;
  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ssd_pkg::CFG_W-1:0] cfg_data;
  logic s_tvalid, s_tready;
  // coef_re, coef_im, grid_re, grid_im, sharpen_weight, dehalo_weight (lowest first)
  logic [127:0] s_tdata;
  logic m_tvalid, m_tready;
  // result_re, result_im (lowest first)
  logic [47:0] m_tdata;

  int errors, pending, checked;
  int idle_count;
  int items_sent;
  bit gaps_on;     // phase-wide switch for random idling on both sides
  bit stall_req;   // asks the receiver for one long hold-off

  spectral_sharpen_dehalo_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
  );

  ssd_bin_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  // Random bin: full-range coefficients most of the time, small ones otherwise
  // so that the power lands inside the interesting part of the factor curves.
  function automatic logic [127:0] rand_bin();
    logic [127:0] d;
    d = {$urandom(), $urandom(), $urandom(), $urandom()};
    if ($urandom_range(3) == 0) begin
      d[23:0]  = 24'($signed(10'($urandom())));
      d[47:24] = 24'($signed(12'($urandom())));
      d[71:48] = 24'($signed(9'($urandom())));
      d[95:72] = 24'($signed(9'($urandom())));
    end
    return d;
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      m_tready <= (gap_len() == 0);
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("tb_spectral_sharpen_dehalo_core: FAIL");
      $finish;
    end
  end

  task automatic send_bin(logic [127:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic write_reg(logic [ssd_pkg::CFG_IDX_W-1:0] idx, logic [ssd_pkg::CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Wait until every predicted bin has come back, then let the pipe drain.
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(logic [15:0] sg, logic [15:0] dg, logic [47:0] smin,
                             logic [47:0] smax, logic [47:0] ht, logic [15:0] gf, bit de);
    write_reg(ssd_pkg::CFG_SHARPEN_GAIN, {32'd0, sg});
    write_reg(ssd_pkg::CFG_DEHALO_GAIN, {32'd0, dg});
    write_reg(ssd_pkg::CFG_SIGMA_MIN, smin);
    write_reg(ssd_pkg::CFG_SIGMA_MAX, smax);
    write_reg(ssd_pkg::CFG_HALO_THRESH, ht);
    write_reg(ssd_pkg::CFG_GRID_FRACTION, {32'd0, gf});
    write_reg(ssd_pkg::CFG_DEGRID_ENABLE, {47'd0, de});
    // Garbage to an unused index must change nothing.
    write_reg(CFG_UNUSED_IDX, rand48());
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [127:0] d;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    gaps_on = 1'b1;
    stall_req = 1'b0;
    idle_count = 0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: both factors and degrid on, extremes of every field.
    load_config(16'd4096, 16'd4096, 48'h100, 48'h1000_0000, 48'h1000, 16'h8000, 1'b1);
    send_bin({16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    send_bin({16'h0000, 16'h0000, 24'h800000, 24'h800000, 24'h800000, 24'h800000});
    send_bin({16'hFFFF, 16'h0000, 24'h0, 24'h0, 24'h0, 24'h0});
    send_bin({16'h0000, 16'hFFFF, 24'h000001, 24'hFFFFFF, 24'hFFFFFF, 24'h000001});
    // Grid of opposite sign pushes the corrected bin's magnitude past 2^23: power saturates.
    send_bin({16'h1000, 16'h1000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000});
    send_bin({16'h1000, 16'h1000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF});
    send_bin({16'h1000, 16'h1000, 24'h0, 24'h0, 24'h000100, 24'hFFFF00});
    send_bin({16'h8000, 16'h0001, 24'h0, 24'h0, 24'h000400, 24'h000200});
    drain_pipe();
    // Large positive gain and weight: factor far above range, output saturates.
    load_config(16'h7FFF, 16'd0, 48'd0, ssd_pkg::PMAX, 48'd0, 16'hFFFF, 1'b1);
    send_bin({16'h0000, 16'hFFFF, 24'h001000, 24'hFFF000, 24'h004000, 24'h004000});
    send_bin({16'h0000, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h123456, 24'h7FFFFF});
    send_bin({16'h0000, 16'h0000, 24'h000010, 24'h000010, 24'h000300, 24'hFFFD00});
    drain_pipe();
    // Most negative gain: factor goes below zero and the bin is inverted.
    load_config(16'h8000, 16'd0, 48'd0, 48'h1_0000_0000, 48'd0, 16'd0, 1'b0);
    send_bin({16'h0000, 16'hFFFF, 24'h0, 24'h0, 24'h000800, 24'hFFF800});
    send_bin({16'h0000, 16'h4000, 24'h0, 24'h0, 24'h7FFFFF, 24'h800000});
    send_bin({16'h0000, 16'h1000, 24'h0, 24'h0, 24'h000001, 24'h000000});
    drain_pipe();
    // Sigma max zero: sharpening collapses to unity while dehalo works.
    load_config(16'h7FFF, 16'hFFFF, ssd_pkg::PMAX, 48'd0, ssd_pkg::PMAX, 16'h0001, 1'b1);
    send_bin({16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000});
    send_bin({16'hFFFF, 16'hFFFF, 24'h000100, 24'hFFFF00, 24'h7FFFFF, 24'h7FFFFF});
    send_bin({16'h8000, 16'h8000, 24'h0, 24'h0, 24'h000000, 24'h000000});
    drain_pipe();

    // Random phases: extremes, a pass-through phase and random settings.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_config(16'd0, 16'd0, rand48(), rand48(), rand48(), 16'hFFFF, 1'b1);
        1: load_config(16'h7FFF, 16'hFFFF, 48'd0, ssd_pkg::PMAX, 48'd0, 16'hFFFF, 1'b1);
        2: load_config(16'h8000, 16'd0, ssd_pkg::PMAX, ssd_pkg::PMAX, ssd_pkg::PMAX,
                       16'd0, 1'b0);
        3: load_config(16'd0, 16'h1000, 48'd0, 48'd0, 48'h10000, 16'h4000, 1'b1);
        default: load_config(16'($urandom()), 16'($urandom()), 48'($urandom()) << 8,
                             rand48() >> $urandom_range(40), rand48() >> $urandom_range(44),
                             16'($urandom()), 1'($urandom()));
      endcase
      gaps_on = (ph % 3 != 2);
      if (ph == 4) stall_req = 1'b1;
      for (int n = 0; n < 90; n++) begin
        d = rand_bin();
        send_bin(d);
      end
      // Sender pause: everything outstanding comes back before the next phase.
      drain_pipe();
    end

    $display("Sent %0d bins over %0d register settings; %0d results checked.",
             items_sent, PHASES + 4, checked);
    $display("Covered pass-through, degrid, sharpen, dehalo, saturation and a long stall.");
    if (errors == 0) begin
      $display("tb_spectral_sharpen_dehalo_core: PASS");
    end else begin
      $display("tb_spectral_sharpen_dehalo_core: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ssd_pkg.sv
rtl/ssd_div_pipe.sv
rtl/ssd_sqrt_pipe.sv
rtl/spectral_sharpen_dehalo_core.sv
rtl/ssd_chk.sv
sim/ssd_bin_checker.sv
sim/tb_spectral_sharpen_dehalo_core.sv
